[hdl/tbrl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the token-bucket rate limiter.
// Has no dependencies; every other file in the project refers to it.

package tbrl_pkg;

    // Field widths
    localparam int unsigned RATE_W  = 25;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PROD_W  = RATE_W + WORD_W;
    localparam int unsigned CFG_A_W = 1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_FILL_RATE   = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_BURST_LIMIT = 1'd1;

    // Reset value of the fill rate
    localparam logic [RATE_W-1:0] RATE_RESET = 25'd1024;

    // Command codes of an input item
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_WITHDRAW = 1'b1;

    // Request from the sequencer to the serial divider
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

endpackage

[hdl/tbrl_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result items.
// Depends on tbrl_pkg for the field widths.

interface tbrl_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [tbrl_pkg::WORD_W-1:0] amount;

    modport source (output valid, output cmd, output amount, input ready);
    modport sink   (input valid, input cmd, input amount, output ready);
endinterface

interface tbrl_out_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [tbrl_pkg::WORD_W-1:0] tokens_left;
    logic [tbrl_pkg::WORD_W-1:0] wait_ticks;

    modport source (output valid, output granted, output tokens_left,
                    output wait_ticks, input ready);
    modport sink   (input valid, input granted, input tokens_left,
                    input wait_ticks, output ready);
endinterface

[hdl/tbrl_div.sv]
`timescale 1ns / 1ps
// Serial restoring divider giving the quotient rounded up, one bit a cycle.
// Depends on tbrl_pkg for div_req_t and the field widths.

module tbrl_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbrl_pkg::div_req_t          req,
    output logic                        done,
    output logic [tbrl_pkg::WORD_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(tbrl_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tbrl_pkg::WORD_W - 1);

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_RUN   = 3'b010,
        DV_ROUND = 3'b100
    } dv_state_t;

    dv_state_t                      state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [tbrl_pkg::RATE_W-1:0]    divisor_reg;
    logic [tbrl_pkg::RATE_W-1:0]    rem_reg;
    logic [tbrl_pkg::WORD_W-1:0]    quot_reg;
    logic [tbrl_pkg::RATE_W:0]      shifted;
    logic [tbrl_pkg::RATE_W:0]      diff;
    logic                           fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quot_reg[tbrl_pkg::WORD_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    // Step sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DV_RUN;
                    cnt_next   = '0;
                end
            end
            DV_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = DV_ROUND;
                end
            end
            DV_ROUND:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Remainder and quotient shift register; the dividend shifts out at the top.
    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && req.start)
        begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quot_reg    <= req.dividend;
        end
        else if (state_reg == DV_RUN)
        begin
            rem_reg  <= fits ? diff[tbrl_pkg::RATE_W-1:0]
                             : shifted[tbrl_pkg::RATE_W-1:0];
            quot_reg <= {quot_reg[tbrl_pkg::WORD_W-2:0], fits};
        end
    end

    // A non-zero remainder rounds the quotient up by one.
    assign done     = (state_reg == DV_ROUND);
    assign quotient = quot_reg + tbrl_pkg::WORD_W'(rem_reg != '0);

    // A new division is only ever requested while the unit is free.
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == DV_IDLE)
        else $error("divider started while busy");

    // The rounding phase follows in the cycle after the last step.
    a_round_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DV_RUN && cnt_reg == LAST_STEP) |=> done)
        else $error("divider skipped its rounding phase");

    // The remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DV_ROUND) |-> rem_reg < divisor_reg)
        else $error("divider remainder not reduced");

endmodule

[hdl/token_bucket_rate_limiter.sv]
`timescale 1ns / 1ps
// Top level of the token-bucket rate limiter: state, sequencer and result register.
// Depends on tbrl_pkg, the channel interfaces in tbrl_if and the divider tbrl_div.
//
//  Channel   Direction  Contents
//  item      in         cmd (tick or withdraw), amount
//  result    out        granted, tokens_left, wait_ticks
//  cfg       in         cfg_wr_en, cfg_index, cfg_wdata (fill_rate, burst_limit)
//
// A tick, or a withdraw the bucket already covers, goes straight to the done state and loads the result.
// A refill adds a multiply step and an add-and-saturate step; when it
// leaves the bucket short of full at a non-zero rate, the serial divider (32 steps and a
// rounding phase) follows before the result loads.
// Reset clears the bucket, the tick count and the wait, and sets the fill rate to 1024.
// The next item is taken the cycle after a result loads, even while that result is stalled.

module token_bucket_rate_limiter
(
    input  logic                               clk,
    input  logic                               rst_n,
    tbrl_in_if.sink                            item,
    tbrl_out_if.source                         result,
    input  logic                               cfg_wr_en,
    input  logic [tbrl_pkg::CFG_A_W-1:0]       cfg_index,
    input  logic [tbrl_pkg::WORD_W-1:0]        cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [tbrl_pkg::WORD_W-1:0] WORD_MAX = '1;

    state_t                          state_reg, state_next;
    logic [tbrl_pkg::RATE_W-1:0]     rate_reg;
    logic [tbrl_pkg::WORD_W-1:0]     burst_reg;
    logic [tbrl_pkg::WORD_W-1:0]     token_count_reg, token_count_next;
    logic [tbrl_pkg::WORD_W-1:0]     elapsed_reg, elapsed_next;
    logic [tbrl_pkg::WORD_W-1:0]     fill_wait_reg, fill_wait_next;
    logic                            cmd_reg;
    logic [tbrl_pkg::WORD_W-1:0]     amount_reg;
    logic [tbrl_pkg::PROD_W-1:0]     prod_reg;
    logic [tbrl_pkg::PROD_W:0]       grown;
    logic [tbrl_pkg::WORD_W-1:0]     refilled;
    logic                            out_valid_reg, out_valid_next;
    logic                            granted_reg;
    logic [tbrl_pkg::WORD_W-1:0]     tokens_out_reg;
    logic [tbrl_pkg::WORD_W-1:0]     wait_out_reg;
    logic                            accept;
    logic                            out_load;
    logic                            grant;
    tbrl_pkg::div_req_t              div_req;
    logic                            div_done;
    logic [tbrl_pkg::WORD_W-1:0]     div_quot;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= tbrl_pkg::RATE_RESET;
            burst_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tbrl_pkg::REG_FILL_RATE:   rate_reg  <= cfg_wdata[tbrl_pkg::RATE_W-1:0];
                tbrl_pkg::REG_BURST_LIMIT: burst_reg <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // Refill arithmetic: grown tokens saturate at the burst limit.
    always_comb
    begin
        grown    = {{(tbrl_pkg::PROD_W + 1 - tbrl_pkg::WORD_W){1'b0}}, token_count_reg}
                 + {1'b0, prod_reg};
        refilled = (grown > {{(tbrl_pkg::PROD_W + 1 - tbrl_pkg::WORD_W){1'b0}}, burst_reg})
                 ? burst_reg : grown[tbrl_pkg::WORD_W-1:0];
    end

    // The result register loads when it is empty or its content is being taken.
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign grant    = (cmd_reg == tbrl_pkg::CMD_WITHDRAW) && (token_count_reg >= amount_reg);

    // Divider request, issued when a refill leaves the bucket short of full at a non-zero fill rate.
    always_comb
    begin
        div_req.start    = (state_reg == ST_ADD) && (refilled < burst_reg) && (rate_reg != '0);
        div_req.dividend = burst_reg - refilled;
        div_req.divisor  = rate_reg;
    end

    // Sequencer and bucket state.
    always_comb
    begin
        state_next       = state_reg;
        token_count_next = token_count_reg;
        elapsed_next     = elapsed_reg;
        fill_wait_next   = fill_wait_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == tbrl_pkg::CMD_TICK)
                    begin
                        if (elapsed_reg != WORD_MAX)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (token_count_reg < item.amount)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                token_count_next = refilled;
                elapsed_next     = '0;
                if (div_req.start)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    fill_wait_next = (refilled < burst_reg) ? WORD_MAX : '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    fill_wait_next = div_quot;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    if (grant)
                    begin
                        token_count_next = token_count_reg - amount_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid drops once taken unless a new result loads.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            token_count_reg <= '0;
            elapsed_reg     <= '0;
            fill_wait_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            token_count_reg <= token_count_next;
            elapsed_reg     <= elapsed_next;
            fill_wait_reg   <= fill_wait_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Item capture, product register and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= item.cmd;
            amount_reg <= item.amount;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= elapsed_reg * rate_reg;
        end
        if (out_load)
        begin
            granted_reg    <= grant;
            tokens_out_reg <= token_count_next;
            wait_out_reg   <= fill_wait_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.granted     = granted_reg;
    assign result.tokens_left = tokens_out_reg;
    assign result.wait_ticks  = wait_out_reg;

    // Serial divider for the wait until full.
    tbrl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A transfer on the item channel always starts work on it.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item was not processed");

    // A refill never leaves more tokens than the burst limit allowed.
    a_refill_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> token_count_reg <= $past(burst_reg))
        else $error("refill exceeded the burst limit");

    // A refill always clears the tick count.
    a_refill_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> elapsed_reg == '0)
        else $error("tick count survived a refill");

    // The divider is only waited on after it was started.
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && $past(state_reg) == ST_ADD) |-> $past(div_req.start))
        else $error("waiting on a divider that was never started");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for token_bucket_rate_limiter: directed and random traffic.
// Depends on tbrl_pkg, the channel interfaces in tbrl_if and the RTL of the block.

module testbench;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 235;
    localparam int RANDOM_PHASES = 8;

    typedef struct {
        logic                        cmd;
        logic [tbrl_pkg::WORD_W-1:0] amount;
    } bucket_req_t;

    typedef struct {
        logic                        granted;
        logic [tbrl_pkg::WORD_W-1:0] tokens_left;
        logic [tbrl_pkg::WORD_W-1:0] wait_ticks;
    } bucket_res_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_wr_en;
    logic [tbrl_pkg::CFG_A_W-1:0]  cfg_index;
    logic [tbrl_pkg::WORD_W-1:0]   cfg_wdata;

    tbrl_in_if  in_ch ();
    tbrl_out_if out_ch ();

    // Items waiting to be sent and results still to arrive.
    bucket_req_t pending_items[$];
    bucket_res_t expected_results[$];

    // Our own copy of the registers and of the bucket.
    logic [tbrl_pkg::RATE_W-1:0] rate_cfg      = tbrl_pkg::RATE_RESET;
    logic [tbrl_pkg::WORD_W-1:0] burst_cfg     = '0;
    logic [tbrl_pkg::WORD_W-1:0] bucket_level  = '0;
    logic [tbrl_pkg::WORD_W-1:0] ticks_pending = '0;
    logic [tbrl_pkg::WORD_W-1:0] refill_wait   = '0;

    int  error_count  = 0;
    int  quiet_cycles = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    bit  idling_on    = 1'b1;
    bucket_req_t next_req;
    bucket_res_t want;

    token_bucket_rate_limiter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Works out the result of one accepted item and moves the bucket on.
    task automatic predict_outcome(input logic cmd,
                                   input logic [tbrl_pkg::WORD_W-1:0] amount);
        logic [63:0] grown;
        logic [63:0] shortfall;
        bucket_res_t res;
        res.granted = 1'b0;
        if (cmd == tbrl_pkg::CMD_TICK)
        begin
            if (ticks_pending != '1)
            begin
                ticks_pending++;
            end
        end
        else
        begin
            // A shortfall triggers the lazy refill before the grant decision.
            if (bucket_level < amount)
            begin
                grown = 64'(bucket_level) + 64'(ticks_pending) * 64'(rate_cfg);
                if (grown > 64'(burst_cfg))
                begin
                    grown = 64'(burst_cfg);
                end
                bucket_level  = grown[tbrl_pkg::WORD_W-1:0];
                ticks_pending = '0;
                if (bucket_level >= burst_cfg)
                begin
                    refill_wait = '0;
                end
                else if (rate_cfg == '0)
                begin
                    refill_wait = '1;
                end
                else
                begin
                    shortfall   = 64'(burst_cfg - bucket_level);
                    refill_wait = 32'((shortfall + 64'(rate_cfg) - 64'd1) / 64'(rate_cfg));
                end
            end
            if (bucket_level >= amount)
            begin
                bucket_level = bucket_level - amount;
                res.granted  = 1'b1;
            end
        end
        res.tokens_left = bucket_level;
        res.wait_ticks  = refill_wait;
        expected_results.push_back(res);
    endtask

    task automatic queue_item(input logic cmd, input logic [tbrl_pkg::WORD_W-1:0] amount);
        bucket_req_t req;
        req.cmd    = cmd;
        req.amount = amount;
        pending_items.push_back(req);
    endtask

    // Returns once every item has been sent and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    endtask

    // Writes both registers while the block is idle.
    task automatic set_regs(input logic [tbrl_pkg::WORD_W-1:0] rate,
                            input logic [tbrl_pkg::WORD_W-1:0] burst);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tbrl_pkg::REG_FILL_RATE;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_index <= tbrl_pkg::REG_BURST_LIMIT;
        cfg_wdata <= burst;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rate_cfg  = rate[tbrl_pkg::RATE_W-1:0];
        burst_cfg = burst;
        @(negedge clk);
    endtask

    // Runs of ticks, each followed by one or two withdraws, most of them sized to the settings.
    task automatic queue_random_phase(input logic [tbrl_pkg::RATE_W-1:0] rate,
                                      input logic [tbrl_pkg::WORD_W-1:0] burst,
                                      input int count);
        int queued;
        logic [63:0] cap;
        logic [tbrl_pkg::WORD_W-1:0] amount;
        queued = 0;
        while (queued < count)
        begin
            repeat ($urandom_range(6, 0))
            begin
                queue_item(tbrl_pkg::CMD_TICK, $urandom());
                queued++;
            end
            repeat (($urandom_range(3, 0) == 0) ? 2 : 1)
            begin
                case ($urandom_range(9, 0))
                    0: amount = '0;
                    1: amount = ($urandom_range(1, 0) != 0) ? '1 : $urandom();
                    2, 3, 4, 5: amount = $urandom_range(burst, 0);
                    default:
                    begin
                        cap = 64'(rate) * 64'($urandom_range(8, 1));
                        if (cap > 64'(burst))
                        begin
                            cap = 64'(burst);
                        end
                        amount = $urandom_range(cap[tbrl_pkg::WORD_W-1:0], 0);
                    end
                endcase
                queue_item(tbrl_pkg::CMD_WITHDRAW, amount);
                queued++;
            end
        end
    endtask

    // Input driver: presents queued items, with occasional bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            in_ch.cmd    <= tbrl_pkg::CMD_TICK;
            in_ch.amount <= '0;
            send_gap = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                next_req = pending_items.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.cmd    <= next_req.cmd;
                in_ch.amount <= next_req.amount;
                if (idling_on && $urandom_range(9, 0) == 0)
                begin
                    send_gap = $urandom_range(11, 1);
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Each input transfer updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_outcome(in_ch.cmd, in_ch.amount);
        end
    end

    // Result monitor: checks each transfer and stalls the block at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_failure($sformatf(
                        "result with none pending: granted=%0d tokens=%0d wait=%0d",
                        out_ch.granted, out_ch.tokens_left, out_ch.wait_ticks));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.granted !== want.granted
                        || out_ch.tokens_left !== want.tokens_left
                        || out_ch.wait_ticks !== want.wait_ticks)
                    begin
                        report_failure($sformatf(
                            "expected granted/tokens/wait %0d/%0d/%0d, got %0d/%0d/%0d",
                            want.granted, want.tokens_left, want.wait_ticks,
                            out_ch.granted, out_ch.tokens_left, out_ch.wait_ticks));
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (idling_on && $urandom_range(9, 0) == 0)
                begin
                    stall_left = $urandom_range(11, 1);
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus: directed phases, random phases, then the final verdict.
    initial
    begin
        logic [tbrl_pkg::WORD_W-1:0] rate_pick;
        logic [tbrl_pkg::WORD_W-1:0] burst_pick;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = tbrl_pkg::REG_FILL_RATE;
        cfg_wdata    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a zero amount is granted, anything more meets an empty bucket.
        queue_item(tbrl_pkg::CMD_WITHDRAW, '0);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd1);
        queue_item(tbrl_pkg::CMD_TICK, '1);
        queue_item(tbrl_pkg::CMD_WITHDRAW, '1);
        wait_drained();

        // Partial refill, a withdraw covered without refill, a refusal, then a refill to full.
        set_regs(32'd1024, 32'd5000);
        repeat (3) queue_item(tbrl_pkg::CMD_TICK, '0);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd2000);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd1000);
        queue_item(tbrl_pkg::CMD_WITHDRAW, '1);
        repeat (5) queue_item(tbrl_pkg::CMD_TICK, $urandom());
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd100);
        wait_drained();

        // Burst lowered below the tokens held; the rate write carries bits beyond its width.
        set_regs('1, 32'd100);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd6000);
        wait_drained();

        // Zero fill rate with a bucket that is not full.
        set_regs('0, '1);
        repeat (2) queue_item(tbrl_pkg::CMD_TICK, '0);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd200);
        wait_drained();

        // A fill rate of 16777216 against the largest burst.
        set_regs(32'd16777216, '1);
        repeat (2) queue_item(tbrl_pkg::CMD_TICK, '0);
        queue_item(tbrl_pkg::CMD_WITHDRAW, '1);
        queue_item(tbrl_pkg::CMD_WITHDRAW, 32'd33554532);
        wait_drained();

        // Random phases, each with its own settings; the last one runs without idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(7, 0))
                0: rate_pick = '0;
                1: rate_pick = 32'd1;
                2: rate_pick = 32'd1024;
                3: rate_pick = 32'd16777216;
                4: rate_pick = 32'h01FF_FFFF;
                5: rate_pick = $urandom();
                default: rate_pick = $urandom_range(4096, 1);
            endcase
            case ($urandom_range(5, 0))
                0: burst_pick = '0;
                1: burst_pick = '1;
                2: burst_pick = $urandom();
                default: burst_pick = $urandom_range(32'h0010_0000, 1);
            endcase
            idling_on = (phase != RANDOM_PHASES - 1);
            set_regs(rate_pick, burst_pick);
            queue_random_phase(rate_cfg, burst_cfg, PHASE_ITEMS);
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
